### src/vpd_pkg.sv
// Package for the variable-length packet deframer.
// Holds the parse phase type, the result struct and the sizing constants.
// Used by every module in src.
package vpd_pkg;

	localparam int LEN_BITS_DEF = 30;
	localparam int ACC_BITS     = 22;

	localparam logic [7:0] MSB_MASK = 8'h80;

	typedef enum logic [5:0] {
		PH_CODE = 6'b000001,
		PH_LEN1 = 6'b000010,
		PH_LEN2 = 6'b000100,
		PH_LEN3 = 6'b001000,
		PH_LEN4 = 6'b010000,
		PH_DATA = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [7:0] code;
		logic [7:0] data;
		logic       empty;
		logic       last;
	} result_t;

endpackage

### src/vpd_in_reg.sv
// Input register of the deframer: captures one received byte per cycle while rx_stall is low.
// Depends on vpd_pkg only by convention; the stall toward the sender follows advance.
module vpd_in_reg import vpd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	logic take;

	assign rx_stall = valid_s1 && !advance;
	assign take     = rx_valid && !rx_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

### src/vpd_parser.sv
// Parse state of the deframer: code, length field and payload count.
// Depends on vpd_pkg for phase_t and result_t; produces at most one result per byte.
module vpd_parser import vpd_pkg::*; #(
	parameter int LEN_BITS = LEN_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] byte_s1,
	output logic       res_valid,
	output result_t    res
);

	phase_t                phase_q, phase_d;
	logic [7:0]            code_q, code_d;
	logic [ACC_BITS-1:0]   acc_q, acc_d;
	logic [LEN_BITS-1:0]   rem_q, rem_d;
	logic [LEN_BITS-1:0]   len;
	logic [ACC_BITS+7:0]   full_len;
	logic                  have_len;
	logic [LEN_BITS-1:0]   rem_dec;

	assign full_len = {byte_s1, acc_q};
	assign rem_dec  = rem_q - LEN_BITS'(1);

	always_comb begin
		phase_d   = phase_q;
		code_d    = code_q;
		acc_d     = acc_q;
		rem_d     = rem_q;
		have_len  = 1'b0;
		len       = '0;
		res_valid = 1'b0;
		res.code  = code_q;
		res.data  = byte_s1;
		res.empty = 1'b0;
		res.last  = 1'b0;
		case (phase_q)
			PH_LEN1: begin
				acc_d[6:0] = byte_s1[6:0];
				if ((byte_s1 & MSB_MASK) == 8'h00) begin
					have_len = 1'b1;
					len      = LEN_BITS'(byte_s1[6:0]);
				end else begin
					phase_d = PH_LEN2;
				end
			end
			PH_LEN2: begin
				acc_d[13:7] = byte_s1[6:0];
				if ((byte_s1 & MSB_MASK) == 8'h00) begin
					have_len = 1'b1;
					len      = LEN_BITS'({byte_s1[6:0], acc_q[6:0]});
				end else begin
					phase_d = PH_LEN3;
				end
			end
			PH_LEN3: begin
				acc_d[21:14] = byte_s1;
				phase_d      = PH_LEN4;
			end
			PH_LEN4: begin
				have_len = 1'b1;
				len      = full_len[LEN_BITS-1:0];
			end
			PH_DATA: begin
				res_valid = 1'b1;
				rem_d     = rem_dec;
				if (rem_dec == '0) begin
					res.last = 1'b1;
					phase_d  = PH_CODE;
				end
			end
			default: begin
				code_d  = byte_s1;
				rem_d   = '0;
				phase_d = PH_LEN1;
			end
		endcase
		if (have_len) begin
			if (len == '0) begin
				res_valid = 1'b1;
				res.data  = 8'h00;
				res.empty = 1'b1;
				res.last  = 1'b1;
				rem_d     = '0;
				phase_d   = PH_CODE;
			end else begin
				rem_d   = len;
				phase_d = PH_DATA;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CODE;
			code_q  <= 8'h00;
			rem_q   <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			code_q  <= code_d;
			rem_q   <= rem_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			acc_q <= acc_d;
		end
	end

	a_data_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (rem_q != '0))
		else $error("payload phase with zero bytes remaining");

	a_last_returns_to_code: assert property (@(posedge clk) disable iff (!arst_n)
		(take && phase_q == PH_DATA && rem_q == LEN_BITS'(1)) |=> (phase_q == PH_CODE))
		else $error("final payload byte did not end the packet");

endmodule

### src/vpd_out_reg.sv
// Result register of the deframer: holds one result until the receiver takes it.
// Depends on vpd_pkg for result_t; tells the input side when a byte may advance.
module vpd_out_reg import vpd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_s1,
	input  logic       res_valid,
	input  result_t    res,
	output logic       advance,
	output logic       pkt_valid,
	input  logic       pkt_stall,
	output logic [7:0] packet_code,
	output logic [7:0] payload_byte,
	output logic       is_empty,
	output logic       is_last
);

	logic    valid_q;
	result_t res_q;
	logic    load;

	assign advance = valid_s1 && (!valid_q || !pkt_stall);
	assign load    = advance && res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!pkt_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign pkt_valid    = valid_q;
	assign packet_code  = res_q.code;
	assign payload_byte = res_q.data;
	assign is_empty     = res_q.empty;
	assign is_last      = res_q.last;

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_q)
		else $error("loaded result not presented");

	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && res_q.empty) |-> (res_q.last && res_q.data == 8'h00))
		else $error("empty result without last marker or with data");

endmodule

### src/varlen_packet_deframer_top.sv
// Top level of the variable-length packet deframer.
// Instantiates vpd_in_reg, vpd_parser and vpd_out_reg; uses vpd_pkg.
//
//   channel  valid      stall      payload
//   rx       rx_valid   rx_stall   rx_byte
//   pkt      pkt_valid  pkt_stall  packet_code, payload_byte, is_empty, is_last
//
// One byte per cycle while rx_stall is low; a result passes the input register, then vpd_out_reg.
// Rate is set by the single parse-state update per byte in vpd_parser.
// Reset (arst_n low) returns the parser to the code byte phase and empties both registers.
// A stalled result holds the parser on every byte; the input register then fills and stalls rx.
module varlen_packet_deframer_top import vpd_pkg::*; #(
	parameter int LEN_BITS = LEN_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       pkt_valid,
	input  logic       pkt_stall,
	output logic [7:0] packet_code,
	output logic [7:0] payload_byte,
	output logic       is_empty,
	output logic       is_last
);

	logic       advance;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       res_valid;
	result_t    res;

	vpd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	vpd_parser #(
		.LEN_BITS (LEN_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (advance),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	vpd_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.res_valid    (res_valid),
		.res          (res),
		.advance      (advance),
		.pkt_valid    (pkt_valid),
		.pkt_stall    (pkt_stall),
		.packet_code  (packet_code),
		.payload_byte (payload_byte),
		.is_empty     (is_empty),
		.is_last      (is_last)
	);

endmodule

### test/tb_varlen_packet_deframer_top.sv
// Testbench for varlen_packet_deframer_top: directed table, then random packets.
// Scores every result against a byte-level deframer predictor, or fixed rows against the table; uses vpd_pkg.
// Needs only src/vpd_pkg.sv and the RTL under src.
module tb_varlen_packet_deframer_top import vpd_pkg::*; ();

	localparam int LEN_W    = LEN_BITS_DEF;
	localparam int N_DIR    = 24;
	localparam int N_RANDOM = 1700;

	typedef struct packed {
		logic [7:0] rx;
		logic       fixed;
		result_t    want;
	} stim_row_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       rx_valid = 1'b0;
	logic       rx_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       pkt_valid;
	logic       pkt_stall = 1'b0;
	logic [7:0] packet_code;
	logic [7:0] payload_byte;
	logic       is_empty;
	logic       is_last;

	phase_t      dp_phase = PH_CODE;
	logic [7:0]  dp_code = 8'h00;
	logic [29:0] dp_len = '0;
	logic [29:0] dp_left = '0;

	result_t   pending_results [$];
	stim_row_t dir_rows [N_DIR];
	int        n_bytes = 0;
	int        n_results = 0;
	int        n_mismatch = 0;

	varlen_packet_deframer_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_valid    (rx_valid),
		.rx_stall    (rx_stall),
		.rx_byte     (rx_byte),
		.pkt_valid   (pkt_valid),
		.pkt_stall   (pkt_stall),
		.packet_code (packet_code),
		.payload_byte(payload_byte),
		.is_empty    (is_empty),
		.is_last     (is_last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("** varlen_packet_deframer_top: FAILED **");
		$finish;
	end

	function automatic bit close_length(output result_t r);
		r = '0;
		dp_len = dp_len & ((30'd1 << LEN_W) - 30'd1);
		if (dp_len == '0) begin
			r = '{code: dp_code, data: 8'h00, empty: 1'b1, last: 1'b1};
			dp_phase = PH_CODE;
			dp_left = '0;
			return 1'b1;
		end
		dp_left = dp_len;
		dp_phase = PH_DATA;
		return 1'b0;
	endfunction

	function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
		r = '0;
		case (dp_phase)
			PH_LEN1: begin
				dp_len = {23'b0, b[6:0]};
				if (!b[7]) return close_length(r);
				dp_phase = PH_LEN2;
			end
			PH_LEN2: begin
				dp_len = {15'b0, b, dp_len[6:0]};
				if (!dp_len[14]) return close_length(r);
				dp_phase = PH_LEN3;
			end
			PH_LEN3: begin
				dp_len = {8'b0, b, dp_len[13:0]};
				dp_phase = PH_LEN4;
			end
			PH_LEN4: begin
				dp_len = {b, dp_len[21:0]};
				return close_length(r);
			end
			PH_DATA: begin
				dp_left = dp_left - 30'd1;
				r = '{code: dp_code, data: b, empty: 1'b0, last: dp_left == '0};
				if (dp_left == '0) dp_phase = PH_CODE;
				return 1'b1;
			end
			default: begin
				dp_code = b;
				dp_len = '0;
				dp_left = '0;
				dp_phase = PH_LEN1;
			end
		endcase
		return 1'b0;
	endfunction

	task automatic report(input string what);
		n_mismatch++;
		if (n_mismatch <= 100) $display("result %0d: %s", n_results, what);
	endtask

	task automatic send_byte(input logic [7:0] b, input bit fixed, input result_t want);
		int      gap;
		bit      took;
		bit      got;
		result_t r;
		gap = (((n_bytes / 96) % 3) != 2) ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do begin
			@(negedge clk);
			took = !rx_stall;
			@(posedge clk);
		end while (!took);
		n_bytes++;
		got = deframe_byte(b, r);
		if (fixed) begin
			got = 1'b1;
			r = want;
		end
		if (got) pending_results.push_back(r);
	endtask

	task automatic send_packet(input int form, input logic [29:0] len);
		logic [7:0] pay;
		send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
		case (form)
			1: send_byte({1'b0, len[6:0]}, 1'b0, '0);
			2: begin
				send_byte({1'b1, len[6:0]}, 1'b0, '0);
				send_byte({1'b0, len[13:7]}, 1'b0, '0);
			end
			default: begin
				send_byte({1'b1, len[6:0]}, 1'b0, '0);
				send_byte({1'b1, len[13:7]}, 1'b0, '0);
				send_byte(len[21:14], 1'b0, '0);
				send_byte(len[29:22], 1'b0, '0);
			end
		endcase
		repeat (len) begin
			pay = 8'($urandom_range(0, 255));
			send_byte(pay, 1'b0, '0);
		end
	endtask

	initial begin
		int      gap;
		bit      got;
		result_t seen;
		result_t want;
		wait (arst_n === 1'b1);
		forever begin
			gap = (((n_results / 70) % 3) != 1) ? $urandom_range(0, 13) : 0;
			if (n_results == 300) gap = 200;
			if (gap > 0) begin
				pkt_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			pkt_stall <= 1'b0;
			do begin
				@(negedge clk);
				got = pkt_valid;
				seen = {packet_code, payload_byte, is_empty, is_last};
				@(posedge clk);
			end while (!got);
			n_results++;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected result %h", seen));
			end else begin
				want = pending_results.pop_front();
				if (seen.code !== want.code)
					report($sformatf("packet_code %h, want %h", seen.code, want.code));
				if (seen.data !== want.data)
					report($sformatf("payload_byte %h, want %h", seen.data, want.data));
				if (seen.empty !== want.empty)
					report($sformatf("is_empty %b, want %b", seen.empty, want.empty));
				if (seen.last !== want.last)
					report($sformatf("is_last %b, want %b", seen.last, want.last));
			end
		end
	end

	initial begin
		int          pick;
		int          form;
		logic [29:0] len;
		int          start;
		dir_rows = '{
			{8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0},
			{8'h00, 1'b1, 8'h00, 8'h00, 1'b1, 1'b1},
			{8'hFF, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0},
			{8'h01, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0},
			{8'hFF, 1'b1, 8'hFF, 8'hFF, 1'b0, 1'b1},
			{8'h3C, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0},
			{8'h82, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0},
			{8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0},
			{8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0},
			{8'h80, 1'b1, 8'h3C, 8'h80, 1'b0, 1'b1},
			{8'h5A, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0},
			{8'h80, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0},
			{8'h00, 1'b1, 8'h5A, 8'h00, 1'b1, 1'b1},
			{8'h81, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0},
			{8'h80, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0},
			{8'h80, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0},
			{8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0},
			{8'h00, 1'b1, 8'h81, 8'h00, 1'b1, 1'b1},
			{8'h7E, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0},
			{8'h81, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0},
			{8'h80, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0},
			{8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0},
			{8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0},
			{8'h55, 1'b1, 8'h7E, 8'h55, 1'b0, 1'b1}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIR; i++)
			send_byte(dir_rows[i].rx, dir_rows[i].fixed, dir_rows[i].want);

		start = n_bytes;
		while (n_bytes - start < N_RANDOM) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				form = 1;
				len = 30'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) :
					$urandom_range(0, 6));
			end else if (pick < 80) begin
				form = 2;
				len = 30'(($urandom_range(0, 19) == 0) ? $urandom_range(0, 1000) :
					$urandom_range(0, 24));
			end else begin
				form = 4;
				len = 30'($urandom_range(0, 12));
			end
			send_packet(form, len);
		end
		rx_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (n_mismatch == 0)
			$display("** varlen_packet_deframer_top: PASSED **");
		else
			$display("** varlen_packet_deframer_top: FAILED **");
		$finish;
	end

endmodule
